### design/rpci_pkg.sv
// Shared constants, types and register codes for the rigid pose compose/invert block.
// Used by every module of the block; depends on nothing else.
package rpci_pkg;

    localparam int QW       = 16;          // quaternion component width, Q2.14
    localparam int PW       = 32;          // position width, Q16.16
    localparam int FRAC_Q   = 14;          // fractional bits of a quaternion
    localparam int QVW      = QW + 1;      // quaternion after conjugation
    localparam int VW       = PW + 1;      // position after negation
    localparam int CW       = 34;          // raw product quaternion in Q.28
    localparam int NW       = 32;          // quaternion scaled into [2^29, 2^30]
    localparam int NORM_MSB = 29;          // target top bit after scaling
    localparam int SQW      = 2 * NW;      // sum of squares
    localparam int RTW      = SQW / 2;     // square root width
    localparam int QBITS    = 15;          // quotient bits of the final divide
    localparam int CFG_IW   = 3;           // configuration index width
    localparam int SMALL_LIM_BITS = 16;    // components below 2^16 are "small"

    localparam logic [CW:0] DEGEN_SUMSQ_MIN = (CW + 1)'(7205760);
    localparam logic signed [QW-1:0] Q14_ONE = 16'sd16384;

    typedef enum logic [CFG_IW-1:0] {
        CFG_OFFSET_QX = 3'd0,
        CFG_OFFSET_QY = 3'd1,
        CFG_OFFSET_QZ = 3'd2,
        CFG_OFFSET_QW = 3'd3,
        CFG_OFFSET_PX = 3'd4,
        CFG_OFFSET_PY = 3'd5,
        CFG_OFFSET_PZ = 3'd6
    } cfg_index_t;

    typedef logic signed [QVW-1:0] rquat_t;
    typedef logic signed [VW-1:0]  rvec_t;
    typedef logic signed [NW-1:0]  ncomp_t;
    typedef logic signed [PW-1:0]  pos_t;

    // Fields that ride along the divider.
    typedef struct packed {
        logic degen;
        pos_t px;
        pos_t py;
        pos_t pz;
    } tail_t;

    // Fields that ride along the square root.
    typedef struct packed {
        ncomp_t cx;
        ncomp_t cy;
        ncomp_t cz;
        ncomp_t cw;
        tail_t  tail;
    } norm_side_t;

    localparam int SQRT_SIDE_W = $bits(norm_side_t);
    localparam int DIV_SIDE_W  = $bits(tail_t);

endpackage

### design/rigid_pose_compose_invert.sv
// Top level of the rigid pose compose/invert block: offset registers, quaternion product,
// scaling stages and the output register. Depends on rpci_pkg, rpci_rotate, rpci_sqrt, rpci_div.

// The block takes one word per cycle while it is not stalled and returns one word per
// accepted word, in order. A compose request (req_type 0) returns the base pose times the
// offset pose held in the configuration registers; an invert request returns the inverse of
// the base pose. The result quaternion is renormalized to unit length in Q2.14, and when its
// length is too small the identity quaternion is returned with degenerate set. Positions are
// Q16.16 and saturate. The pipeline is six stages of product, scaling and squaring, sixteen
// stages of the square root (two root bits each), nine stages of the divider (one setup
// stage, then eight stages that form the fifteen quotient bits at most two at a time) and
// the output register, 32 register stages in all; the whole pipeline advances together, and
// it stalls only when a finished word sits in the output register and is not taken.
// Configuration writes are always ready and take effect at once; they should be made while
// no word is in flight.
module rigid_pose_compose_invert (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rpci_pkg::CFG_IW-1:0]        cfg_index,
    input  logic [rpci_pkg::PW-1:0]            cfg_data,
    // input pose channel
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_req_type,
    input  logic signed [rpci_pkg::QW-1:0]     s_base_qx,
    input  logic signed [rpci_pkg::QW-1:0]     s_base_qy,
    input  logic signed [rpci_pkg::QW-1:0]     s_base_qz,
    input  logic signed [rpci_pkg::QW-1:0]     s_base_qw,
    input  logic signed [rpci_pkg::PW-1:0]     s_base_px,
    input  logic signed [rpci_pkg::PW-1:0]     s_base_py,
    input  logic signed [rpci_pkg::PW-1:0]     s_base_pz,
    // result pose channel
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [rpci_pkg::QW-1:0]     m_result_qx,
    output logic signed [rpci_pkg::QW-1:0]     m_result_qy,
    output logic signed [rpci_pkg::QW-1:0]     m_result_qz,
    output logic signed [rpci_pkg::QW-1:0]     m_result_qw,
    output logic signed [rpci_pkg::PW-1:0]     m_result_px,
    output logic signed [rpci_pkg::PW-1:0]     m_result_py,
    output logic signed [rpci_pkg::PW-1:0]     m_result_pz,
    output logic                               m_degenerate
);
    import rpci_pkg::*;

    // The whole pipeline moves one step whenever the output register can take a word.
    logic en;

    // Offset pose registers.
    logic signed [QW-1:0] off_q_reg [4];
    logic signed [PW-1:0] off_p_reg [3];

    logic signed [QW-1:0] base_q [4];
    logic signed [PW-1:0] base_p [3];

    // Stage 1: product quaternion in Q.28 and the operands of the rotation.
    logic signed [2*QW-1:0] pp_w [16];
    logic signed [CW-1:0]   c_cmp [4];
    rquat_t                 conj_w [4];
    logic signed [CW-1:0]   c_next [4];
    rquat_t                 q_next [4];
    rvec_t                  v_next [3];
    pos_t                   pa_next [3];
    logic                   v1_reg;
    logic signed [CW-1:0]   c1_reg [4];
    rquat_t                 q1_reg [4];
    rvec_t                  v1d_reg [3];
    pos_t                   pa1_reg [3];

    // Stage 2: magnitudes, the largest one, and the small-value sum of squares.
    logic [CW-1:0]          ca_w [4];
    logic signed [CW-1:0]   csq_w [4];
    logic [CW-1:0]          m_w;
    logic                   small_w;
    logic [CW:0]            sqs_w;
    logic                   v2_reg;
    logic signed [CW-1:0]   c2_reg [4];
    logic [CW-1:0]          m2_reg;
    logic                   small2_reg;
    logic [CW:0]            sqs2_reg;

    // Stage 3: degenerate test and the scaling shift.
    logic [5:0]             msb_w;
    logic                   rsh_w;
    logic [4:0]             amt_w;
    logic                   v3_reg;
    logic signed [CW-1:0]   c3_reg [4];
    logic                   degen3_reg;
    logic                   rsh3_reg;
    logic [4:0]             amt3_reg;

    // Stage 4: scaled components.
    logic signed [CW:0]     cx_w [4];
    logic signed [CW:0]     cr_w [4];
    logic signed [CW:0]     rnd_w;
    ncomp_t                 cn_next [4];
    logic                   v4_reg;
    ncomp_t                 cn4_reg [4];
    logic                   degen4_reg;

    // Stage 5: squares.
    logic signed [SQW-1:0]  sq_w [4];
    logic                   v5_reg;
    ncomp_t                 cn5_reg [4];
    logic                   degen5_reg;
    logic [SQW-1:0]         sq5_reg [4];

    // Stage 6: sum of squares and the word handed to the square root.
    pos_t                   pos_w [3];
    norm_side_t             side6_next;
    logic                   v6_reg;
    logic [SQW-1:0]         sumsq6_reg;
    norm_side_t             side6_reg;

    // Square root and divider.
    logic                   sq_valid;
    logic [RTW-1:0]         sq_root;
    logic [SQRT_SIDE_W-1:0] sq_side_vec;
    norm_side_t             sq_side;
    ncomp_t                 div_num [4];
    tail_t                  div_tail_in;
    logic                   div_valid;
    logic signed [QW-1:0]   div_quot [4];
    logic [DIV_SIDE_W-1:0]  div_side_vec;
    tail_t                  div_tail;

    // Output register.
    logic                   m_valid_reg;
    logic signed [QW-1:0]   m_q_reg [4];
    pos_t                   m_p_reg [3];
    logic                   m_degen_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;
    assign cfg_ready = 1'b1;

    // Configuration writes; an index past the register list is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_q_reg[0] <= '0;
            off_q_reg[1] <= '0;
            off_q_reg[2] <= '0;
            off_q_reg[3] <= Q14_ONE;
            off_p_reg[0] <= '0;
            off_p_reg[1] <= '0;
            off_p_reg[2] <= '0;
        end else if (cfg_valid) begin
            case (cfg_index_t'(cfg_index))
                CFG_OFFSET_QX: off_q_reg[0] <= cfg_data[QW-1:0];
                CFG_OFFSET_QY: off_q_reg[1] <= cfg_data[QW-1:0];
                CFG_OFFSET_QZ: off_q_reg[2] <= cfg_data[QW-1:0];
                CFG_OFFSET_QW: off_q_reg[3] <= cfg_data[QW-1:0];
                CFG_OFFSET_PX: off_p_reg[0] <= cfg_data;
                CFG_OFFSET_PY: off_p_reg[1] <= cfg_data;
                CFG_OFFSET_PZ: off_p_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    assign base_q[0] = s_base_qx;
    assign base_q[1] = s_base_qy;
    assign base_q[2] = s_base_qz;
    assign base_q[3] = s_base_qw;
    assign base_p[0] = s_base_px;
    assign base_p[1] = s_base_py;
    assign base_p[2] = s_base_pz;

    // Components are ordered x, y, z, w. The Hamilton product base * offset is exact in Q.28.
    // An invert request conjugates the base, negates its position and has nothing to add.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                pp_w[4*i+j] = base_q[i] * off_q_reg[j];
            end
        end
        c_cmp[0] = CW'(pp_w[12]) + CW'(pp_w[3])  + CW'(pp_w[6])  - CW'(pp_w[9]);
        c_cmp[1] = CW'(pp_w[13]) - CW'(pp_w[2])  + CW'(pp_w[7])  + CW'(pp_w[8]);
        c_cmp[2] = CW'(pp_w[14]) + CW'(pp_w[1])  - CW'(pp_w[4])  + CW'(pp_w[11]);
        c_cmp[3] = CW'(pp_w[15]) - CW'(pp_w[0])  - CW'(pp_w[5])  - CW'(pp_w[10]);
        for (int i = 0; i < 3; i++) begin
            conj_w[i] = -QVW'(base_q[i]);
        end
        conj_w[3] = QVW'(base_q[3]);
        for (int i = 0; i < 4; i++) begin
            if (s_req_type) begin
                q_next[i] = conj_w[i];
                c_next[i] = CW'(conj_w[i]) <<< FRAC_Q;
            end else begin
                q_next[i] = QVW'(base_q[i]);
                c_next[i] = c_cmp[i];
            end
        end
        for (int i = 0; i < 3; i++) begin
            if (s_req_type) begin
                v_next[i]  = -VW'(base_p[i]);
                pa_next[i] = '0;
            end else begin
                v_next[i]  = VW'(off_p_reg[i]);
                pa_next[i] = base_p[i];
            end
        end
    end

    // A component is small when its magnitude is below 2^16; only when all four are small can
    // the length fall under the degenerate limit, and then their squares fit in 33 bits.
    always_comb begin
        m_w     = '0;
        small_w = 1'b1;
        sqs_w   = '0;
        for (int i = 0; i < 4; i++) begin
            ca_w[i]  = c1_reg[i][CW-1] ? CW'(-c1_reg[i]) : CW'(c1_reg[i]);
            csq_w[i] = $signed(c1_reg[i][SMALL_LIM_BITS:0]) *
                       $signed(c1_reg[i][SMALL_LIM_BITS:0]);
            sqs_w    = sqs_w + {1'b0, csq_w[i]};
            if (ca_w[i] > m_w) begin
                m_w = ca_w[i];
            end
            if (ca_w[i][CW-1:SMALL_LIM_BITS] != '0) begin
                small_w = 1'b0;
            end
        end
    end

    // Find the top set bit of the largest magnitude and the shift that brings it to bit 29.
    always_comb begin
        msb_w = '0;
        for (int i = 0; i < CW; i++) begin
            if (m2_reg[i]) begin
                msb_w = 6'(i);
            end
        end
        rsh_w = (msb_w > 6'(NORM_MSB));
        amt_w = rsh_w ? 5'(msb_w - 6'(NORM_MSB)) : 5'(6'(NORM_MSB) - msb_w);
    end

    // Right shifts round half up; left shifts are exact.
    always_comb begin
        rnd_w = (CW + 1)'(1) <<< (amt3_reg - 5'd1);
        for (int i = 0; i < 4; i++) begin
            cx_w[i] = (CW + 1)'(c3_reg[i]);
            if (rsh3_reg) begin
                cr_w[i] = (cx_w[i] + rnd_w) >>> amt3_reg;
            end else begin
                cr_w[i] = cx_w[i] <<< amt3_reg;
            end
            cn_next[i] = NW'(cr_w[i]);
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            sq_w[i] = cn4_reg[i] * cn4_reg[i];
        end
    end

    always_comb begin
        side6_next.cx        = cn5_reg[0];
        side6_next.cy        = cn5_reg[1];
        side6_next.cz        = cn5_reg[2];
        side6_next.cw        = cn5_reg[3];
        side6_next.tail.degen = degen5_reg;
        side6_next.tail.px   = pos_w[0];
        side6_next.tail.py   = pos_w[1];
        side6_next.tail.pz   = pos_w[2];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c1_reg     <= c_next;
            q1_reg     <= q_next;
            v1d_reg    <= v_next;
            pa1_reg    <= pa_next;
            c2_reg     <= c1_reg;
            m2_reg     <= m_w;
            small2_reg <= small_w;
            sqs2_reg   <= sqs_w;
            c3_reg     <= c2_reg;
            degen3_reg <= small2_reg && (sqs2_reg < DEGEN_SUMSQ_MIN);
            rsh3_reg   <= rsh_w;
            amt3_reg   <= amt_w;
            cn4_reg    <= cn_next;
            degen4_reg <= degen3_reg;
            cn5_reg    <= cn4_reg;
            degen5_reg <= degen4_reg;
            for (int i = 0; i < 4; i++) begin
                sq5_reg[i] <= unsigned'(sq_w[i]);
            end
            sumsq6_reg <= sq5_reg[0] + sq5_reg[1] + sq5_reg[2] + sq5_reg[3];
            side6_reg  <= side6_next;
        end
    end

    // The position path runs beside stages two to five and lands with stage five.
    rpci_rotate u_rotate (
        .aclk   (aclk),
        .en     (en),
        .q_i    (q1_reg),
        .v_i    (v1d_reg),
        .padd_i (pa1_reg),
        .pos_o  (pos_w)
    );

    rpci_sqrt #(
        .SIDE_W (SQRT_SIDE_W)
    ) u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .valid_i (v6_reg),
        .n_i     (sumsq6_reg),
        .side_i  (side6_reg),
        .valid_o (sq_valid),
        .root_o  (sq_root),
        .side_o  (sq_side_vec)
    );

    assign sq_side     = sq_side_vec;
    assign div_num[0]  = sq_side.cx;
    assign div_num[1]  = sq_side.cy;
    assign div_num[2]  = sq_side.cz;
    assign div_num[3]  = sq_side.cw;
    assign div_tail_in = sq_side.tail;

    rpci_div #(
        .SIDE_W (DIV_SIDE_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .valid_i (sq_valid),
        .len_i   (sq_root),
        .num_i   (div_num),
        .side_i  (div_tail_in),
        .valid_o (div_valid),
        .quot_o  (div_quot),
        .side_o  (div_side_vec)
    );

    assign div_tail = div_side_vec;

    // Output register: a degenerate quaternion is replaced by identity.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (div_tail.degen) begin
                m_q_reg[0] <= '0;
                m_q_reg[1] <= '0;
                m_q_reg[2] <= '0;
                m_q_reg[3] <= Q14_ONE;
            end else begin
                m_q_reg <= div_quot;
            end
            m_p_reg[0]  <= div_tail.px;
            m_p_reg[1]  <= div_tail.py;
            m_p_reg[2]  <= div_tail.pz;
            m_degen_reg <= div_tail.degen;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_result_qx  = m_q_reg[0];
    assign m_result_qy  = m_q_reg[1];
    assign m_result_qz  = m_q_reg[2];
    assign m_result_qw  = m_q_reg[3];
    assign m_result_px  = m_p_reg[0];
    assign m_result_py  = m_p_reg[1];
    assign m_result_pz  = m_p_reg[2];
    assign m_degenerate = m_degen_reg;

    // A degenerate word always carries the identity quaternion.
    a_degen_identity: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_degenerate |-> m_result_qx == '0 && m_result_qy == '0 &&
                                    m_result_qz == '0 && m_result_qw == Q14_ONE)
        else $error("degenerate word without identity quaternion");

    // The x and w components of a normalized word never exceed one in magnitude.
    a_unit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_degenerate |-> m_result_qw <= Q14_ONE && m_result_qw >= -Q14_ONE &&
                                     m_result_qx <= Q14_ONE && m_result_qx >= -Q14_ONE)
        else $error("normalized component out of range");

    // Nothing leaves the block in the cycle after a reset.
    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result word present right after reset");

endmodule

### design/rpci_rotate.sv
// Position path: rotates a vector by a quaternion and adds an offset, four register stages.
// Depends on rpci_pkg.
module rpci_rotate (
    input  logic            aclk,
    input  logic            en,
    input  rpci_pkg::rquat_t q_i [4],
    input  rpci_pkg::rvec_t  v_i [3],
    input  rpci_pkg::pos_t   padd_i [3],
    output rpci_pkg::pos_t   pos_o [3]
);
    import rpci_pkg::*;

    localparam int PRW  = QVW + VW;          // q * v
    localparam int DW   = PRW + 3;           // doubled difference plus rounding
    localparam int TW   = DW - FRAC_Q;       // rotation vector t
    localparam int P2W  = QVW + TW;          // q * t
    localparam int SW   = P2W + 2;           // three term sum
    localparam int RW   = SW - FRAC_Q;
    localparam int POSW = RW + 2;

    localparam logic signed [DW-1:0] RND_D = DW'(1) <<< (FRAC_Q - 1);
    localparam logic signed [SW-1:0] RND_S = SW'(1) <<< (FRAC_Q - 1);
    localparam logic signed [POSW-1:0] PMAX = POSW'(32'sh7fffffff);
    localparam logic signed [POSW-1:0] PMIN = POSW'(32'sh80000000);

    logic signed [PRW-1:0] pr_next [6];
    logic signed [PRW-1:0] pr_reg  [6];
    rquat_t q1_reg [4];
    rquat_t q2_reg [4];
    rvec_t  v1_reg [3];
    rvec_t  v2_reg [3];
    rvec_t  v3_reg [3];
    pos_t   pa1_reg [3];
    pos_t   pa2_reg [3];
    pos_t   pa3_reg [3];
    logic signed [DW-1:0]  d_w [3];
    logic signed [TW-1:0]  t_next [3];
    logic signed [TW-1:0]  t_reg  [3];
    logic signed [P2W-1:0] p2_next [9];
    logic signed [P2W-1:0] p2_reg  [9];
    logic signed [SW-1:0]  s_w [3];
    logic signed [RW-1:0]  r_w [3];
    logic signed [POSW-1:0] sum_w [3];
    pos_t pos_next [3];
    pos_t pos_reg  [3];

    // Cross product terms of q_vec x v.
    always_comb begin
        pr_next[0] = q_i[1] * v_i[2];
        pr_next[1] = q_i[2] * v_i[1];
        pr_next[2] = q_i[2] * v_i[0];
        pr_next[3] = q_i[0] * v_i[2];
        pr_next[4] = q_i[0] * v_i[1];
        pr_next[5] = q_i[1] * v_i[0];
    end

    // t = 2 * (q_vec x v), rounded half up to Q.16.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            d_w[i] = DW'(pr_reg[2*i]) - DW'(pr_reg[2*i+1]);
            t_next[i] = TW'(((d_w[i] <<< 1) + RND_D) >>> FRAC_Q);
        end
    end

    always_comb begin
        p2_next[0] = q2_reg[3] * t_reg[0];
        p2_next[1] = q2_reg[3] * t_reg[1];
        p2_next[2] = q2_reg[3] * t_reg[2];
        p2_next[3] = q2_reg[1] * t_reg[2];
        p2_next[4] = q2_reg[2] * t_reg[1];
        p2_next[5] = q2_reg[2] * t_reg[0];
        p2_next[6] = q2_reg[0] * t_reg[2];
        p2_next[7] = q2_reg[0] * t_reg[1];
        p2_next[8] = q2_reg[1] * t_reg[0];
    end

    always_comb begin
        s_w[0] = SW'(p2_reg[0]) + SW'(p2_reg[3]) - SW'(p2_reg[4]);
        s_w[1] = SW'(p2_reg[1]) + SW'(p2_reg[5]) - SW'(p2_reg[6]);
        s_w[2] = SW'(p2_reg[2]) + SW'(p2_reg[7]) - SW'(p2_reg[8]);
        for (int i = 0; i < 3; i++) begin
            r_w[i]   = RW'((s_w[i] + RND_S) >>> FRAC_Q);
            sum_w[i] = POSW'(v3_reg[i]) + POSW'(r_w[i]) + POSW'(pa3_reg[i]);
            if (sum_w[i] > PMAX) begin
                pos_next[i] = PW'(PMAX);
            end else if (sum_w[i] < PMIN) begin
                pos_next[i] = PW'(PMIN);
            end else begin
                pos_next[i] = PW'(sum_w[i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pr_reg  <= pr_next;
            q1_reg  <= q_i;
            v1_reg  <= v_i;
            pa1_reg <= padd_i;
            t_reg   <= t_next;
            q2_reg  <= q1_reg;
            v2_reg  <= v1_reg;
            pa2_reg <= pa1_reg;
            p2_reg  <= p2_next;
            v3_reg  <= v2_reg;
            pa3_reg <= pa2_reg;
            pos_reg <= pos_next;
        end
    end

    assign pos_o = pos_reg;

endmodule

### design/rpci_sqrt.sv
// Pipelined integer square root, two root bits per stage, with a sideband that travels along.
// Depends on rpci_pkg.
module rpci_sqrt #(
    parameter int SIDE_W = rpci_pkg::SQRT_SIDE_W
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     valid_i,
    input  logic [rpci_pkg::SQW-1:0] n_i,
    input  logic [SIDE_W-1:0]        side_i,
    output logic                     valid_o,
    output logic [rpci_pkg::RTW-1:0] root_o,
    output logic [SIDE_W-1:0]        side_o
);
    import rpci_pkg::*;

    localparam int STAGES = RTW / 2;
    localparam int RMW    = RTW + 3;

    logic             vld_reg  [STAGES];
    logic [SQW-1:0]   n_reg    [STAGES];
    logic [RMW-1:0]   rem_reg  [STAGES];
    logic [RTW-1:0]   root_reg [STAGES];
    logic [SIDE_W-1:0] side_reg [STAGES];

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        logic              vld_in;
        logic [SQW-1:0]    n_in;
        logic [RMW-1:0]    rem_in;
        logic [RTW-1:0]    root_in;
        logic [SIDE_W-1:0] side_in;
        logic [RMW-1:0]    rem_nx;
        logic [RTW-1:0]    root_nx;

        if (g == 0) begin : g_first
            assign vld_in  = valid_i;
            assign n_in    = n_i;
            assign rem_in  = '0;
            assign root_in = '0;
            assign side_in = side_i;
        end else begin : g_next
            assign vld_in  = vld_reg[g-1];
            assign n_in    = n_reg[g-1];
            assign rem_in  = rem_reg[g-1];
            assign root_in = root_reg[g-1];
            assign side_in = side_reg[g-1];
        end

        always_comb begin
            logic [RMW+1:0] pre;
            logic [RMW+1:0] trial;
            int idx;
            rem_nx  = rem_in;
            root_nx = root_in;
            for (int k = 0; k < 2; k++) begin
                idx   = RTW - 1 - 2 * g - k;
                pre   = {rem_nx, n_in[2*idx+1 -: 2]};
                trial = {3'b000, root_nx, 2'b01};
                if (pre >= trial) begin
                    pre     = pre - trial;
                    root_nx = {root_nx[RTW-2:0], 1'b1};
                end else begin
                    root_nx = {root_nx[RTW-2:0], 1'b0};
                end
                rem_nx = pre[RMW-1:0];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[g] <= 1'b0;
            end else if (en) begin
                vld_reg[g] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                n_reg[g]    <= n_in;
                rem_reg[g]  <= rem_nx;
                root_reg[g] <= root_nx;
                side_reg[g] <= side_in;
            end
        end
    end

    assign valid_o = vld_reg[STAGES-1];
    assign root_o  = root_reg[STAGES-1];
    assign side_o  = side_reg[STAGES-1];

endmodule

### design/rpci_div.sv
// Four-lane pipelined rounding divider that turns scaled components into unit Q2.14 values.
// Depends on rpci_pkg.
module rpci_div #(
    parameter int SIDE_W = rpci_pkg::DIV_SIDE_W
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     valid_i,
    input  logic [rpci_pkg::RTW-1:0] len_i,
    input  rpci_pkg::ncomp_t         num_i [4],
    input  logic [SIDE_W-1:0]        side_i,
    output logic                     valid_o,
    output logic signed [rpci_pkg::QW-1:0] quot_o [4],
    output logic [SIDE_W-1:0]        side_o
);
    import rpci_pkg::*;

    localparam int DW   = NW + FRAC_Q;
    localparam int REMW = RTW + 1;
    localparam int DST  = (QBITS + 1) / 2;

    logic              vld_reg  [DST+1];
    logic [RTW-1:0]    len_reg  [DST+1];
    logic [SIDE_W-1:0] side_reg [DST+1];
    logic [DW-1:0]     a_reg    [DST+1][4];
    logic              neg_reg  [DST+1][4];
    logic [REMW-1:0]   rem_reg  [DST+1][4];
    logic [QBITS-1:0]  q_reg    [DST+1][4];

    logic [NW-1:0] mag_w [4];
    logic [DW-1:0] a_w   [4];

    // Prepare |num| * 2^14 + len/2 so that a truncating divide rounds half away from zero.
    always_comb begin
        for (int l = 0; l < 4; l++) begin
            mag_w[l] = num_i[l][NW-1] ? NW'(-num_i[l]) : NW'(num_i[l]);
            a_w[l]   = (DW'(mag_w[l]) << FRAC_Q) + DW'(len_i >> 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            len_reg[0]  <= len_i;
            side_reg[0] <= side_i;
            for (int l = 0; l < 4; l++) begin
                a_reg[0][l]   <= a_w[l];
                neg_reg[0][l] <= num_i[l][NW-1];
                rem_reg[0][l] <= REMW'(a_w[l] >> QBITS);
                q_reg[0][l]   <= '0;
            end
        end
    end

    for (genvar g = 1; g <= DST; g++) begin : g_stage
        logic [REMW-1:0]  rem_nx [4];
        logic [QBITS-1:0] q_nx   [4];

        always_comb begin
            logic [REMW:0] pre;
            int j;
            for (int l = 0; l < 4; l++) begin
                rem_nx[l] = rem_reg[g-1][l];
                q_nx[l]   = q_reg[g-1][l];
                for (int k = 0; k < 2; k++) begin
                    j = QBITS - 1 - 2 * (g - 1) - k;
                    if (j >= 0) begin
                        pre = {rem_nx[l], a_reg[g-1][l][j]};
                        if (pre >= (REMW + 1)'(len_reg[g-1])) begin
                            pre     = pre - (REMW + 1)'(len_reg[g-1]);
                            q_nx[l] = {q_nx[l][QBITS-2:0], 1'b1};
                        end else begin
                            q_nx[l] = {q_nx[l][QBITS-2:0], 1'b0};
                        end
                        rem_nx[l] = pre[REMW-1:0];
                    end
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[g] <= 1'b0;
            end else if (en) begin
                vld_reg[g] <= vld_reg[g-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                len_reg[g]  <= len_reg[g-1];
                side_reg[g] <= side_reg[g-1];
                for (int l = 0; l < 4; l++) begin
                    a_reg[g][l]   <= a_reg[g-1][l];
                    neg_reg[g][l] <= neg_reg[g-1][l];
                    rem_reg[g][l] <= rem_nx[l];
                    q_reg[g][l]   <= q_nx[l];
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < 4; l++) begin
            quot_o[l] = neg_reg[DST][l] ? -QW'(q_reg[DST][l]) : QW'(q_reg[DST][l]);
        end
    end

    assign valid_o = vld_reg[DST];
    assign side_o  = side_reg[DST];

endmodule
